/* src/assert_macros.svh */
// Assertion macros used by the upscaler top level.
// Expects signals named clock and reset in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, masked while reset is high
`define PAU_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("pau assertion failed");

// Checked on every rising clock edge, reset included
`define PAU_ASSERT_RST(label, prop) \
   label: assert property (@(posedge clock) (prop)) \
      else $error("pau assertion failed during or after reset");

`endif

/* src/pau_pkg.sv */
// Shared constants, types and codes of the 2x pixel-art upscaler.
// No dependencies; every other file of the block but assert_macros.svh uses it by scoped names.
package pau_pkg;

   // Image geometry
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int WIDTH_W    = COL_W + 1;
   localparam int HEIGHT_W   = ROW_W + 1;

   // Pixel format and colour distance
   localparam int PIXEL_W  = 32;
   localparam int CHAN_W   = 8;
   localparam int THR_W    = 9;
   localparam int THR_SQ_W = 2 * THR_W;
   localparam int SQ_W     = 2 * CHAN_W;
   localparam int DIST_W   = SQ_W + 2;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   // Reset values of the configuration registers
   localparam int WIDTH_RESET  = 1024;
   localparam int HEIGHT_RESET = 1024;
   localparam int THR_RESET    = 48;

   typedef logic [PIXEL_W-1:0]     pixel_type;
   typedef logic [COL_W-1:0]       col_type;
   typedef logic [ROW_W-1:0]       row_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   // Request commands
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   // Register indexes
   localparam csr_index_type REG_IMAGE_WIDTH     = CSR_INDEX_W'(0);
   localparam csr_index_type REG_IMAGE_HEIGHT    = CSR_INDEX_W'(1);
   localparam csr_index_type REG_COLOR_THRESHOLD = CSR_INDEX_W'(2);

   // What the front decides for one block
   typedef struct packed {
      pixel_type bottom;
      col_type   col;
      row_type   row;
      logic      use_top;
      logic      has_left;
      logic      has_right;
      logic      is_drain;
      logic      last;
   } side_type;

   // One block waiting for the back: line store reads plus side info
   typedef struct packed {
      pixel_type center;
      pixel_type top;
      pixel_type right;
      side_type  side;
   } job_type;

   typedef struct packed {
      logic [QCOUNT_W-1:0] count;
   } queue_status_type;

endpackage

/* src/pau_req_if.sv */
// Request channel of the upscaler: command and ARGB pixel.
// Depends on pau_pkg.
interface pau_req_if;
   logic                valid;
   logic                ready;
   logic                command;
   pau_pkg::pixel_type  pixel_color;

   modport source (output valid, command, pixel_color, input ready);
   modport sink   (input valid, command, pixel_color, output ready);
endinterface

/* src/pau_rsp_if.sv */
// Result channel of the upscaler: one 2x2 block with its position.
// Depends on pau_pkg.
interface pau_rsp_if;
   logic                valid;
   logic                ready;
   pau_pkg::pixel_type  top_left;
   pau_pkg::pixel_type  top_right;
   pau_pkg::pixel_type  bottom_left;
   pau_pkg::pixel_type  bottom_right;
   pau_pkg::col_type    block_column;
   pau_pkg::row_type    block_row;
   logic                last_of_frame;

   modport source (output valid, top_left, top_right, bottom_left, bottom_right,
                   block_column, block_row, last_of_frame, input ready);
   modport sink   (input valid, top_left, top_right, bottom_left, bottom_right,
                   block_column, block_row, last_of_frame, output ready);
endinterface

/* src/pau_csr_if.sv */
// Configuration write channel of the upscaler: register index and data.
// Depends on pau_pkg.
interface pau_csr_if;
   logic                                  valid;
   logic                                  ready;
   pau_pkg::csr_index_type                index;
   logic [pau_pkg::CSR_DATA_W-1:0]        data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* src/pau_queue.sv */
// Short FIFO of blocks between the front and the back of the upscaler.
// Depends on pau_pkg.
module pau_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  pau_pkg::job_type           push_job,
   input  logic                       pop,
   output logic                       q_valid,
   output pau_pkg::job_type           q_job,
   output pau_pkg::queue_status_type  status
);

   pau_pkg::job_type                 slot_ff [pau_pkg::QUEUE_DEPTH];
   logic [pau_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [pau_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [pau_pkg::QCOUNT_W-1:0]     count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == pau_pkg::QPTR_W'(pau_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + pau_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == pau_pkg::QPTR_W'(pau_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + pau_pkg::QPTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + pau_pkg::QCOUNT_W'(1);
         2'b01:   count_in = count_ff - pau_pkg::QCOUNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload slots, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign q_valid      = (count_ff != '0);
   assign q_job        = slot_ff[rd_ptr_ff];
   assign status.count = count_ff;

endmodule

/* src/pau_front.sv */
// Front of the upscaler: configuration registers, raster counters, line stores.
// Classifies each request and hands blocks to the queue. Depends on pau_pkg.
module pau_front (
   input  logic                              clock,
   input  logic                              reset,
   pau_req_if.sink                           req,
   pau_csr_if.sink                           csr,
   input  pau_pkg::queue_status_type         q_status,
   output logic                              push,
   output pau_pkg::job_type                  job,
   output logic [pau_pkg::THR_SQ_W-1:0]      thr_sq
);

   // configuration
   logic [pau_pkg::WIDTH_W-1:0]   width_ff, width_in;
   logic [pau_pkg::HEIGHT_W-1:0]  height_ff, height_in;
   logic [pau_pkg::THR_W-1:0]     thr_ff, thr_in;
   logic [pau_pkg::THR_SQ_W-1:0]  thr_sq_ff;

   // raster state
   pau_pkg::col_type              col_ff, col_in;
   pau_pkg::row_type              row_ff, row_in;
   logic                          sel_ff, sel_in;
   logic [pau_pkg::WIDTH_W-1:0]   pend_ff, pend_in;

   // line stores and fetch stage
   pau_pkg::pixel_type            store_a_ff [pau_pkg::MAX_WIDTH];
   pau_pkg::pixel_type            store_b_ff [pau_pkg::MAX_WIDTH];
   pau_pkg::pixel_type            cur0_ff, cur1_ff, old_ff;
   pau_pkg::side_type             side_ff, side_in;
   logic                          fetch_ff, fetch_in;

   logic                          accept;
   logic                          wr_en;
   logic [pau_pkg::WIDTH_W-1:0]   x_next;
   logic [pau_pkg::WIDTH_W-1:0]   eff_w;
   logic [pau_pkg::HEIGHT_W-1:0]  eff_h;
   logic [pau_pkg::HEIGHT_W-1:0]  row_next;
   logic [pau_pkg::QCOUNT_W:0]    room_need;
   pau_pkg::col_type              addr1;

   // room for the fetch in flight and one more
   assign room_need = {1'b0, q_status.count} + (pau_pkg::QCOUNT_W + 1)'(fetch_ff);
   assign req.ready = (room_need < (pau_pkg::QCOUNT_W + 1)'(pau_pkg::QUEUE_DEPTH));
   assign accept    = req.valid && req.ready;
   assign csr.ready = 1'b1;

   // register writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      thr_in    = thr_ff;
      if (csr.valid && csr.ready) begin
         unique case (csr.index)
            pau_pkg::REG_IMAGE_WIDTH:     width_in  = csr.data[pau_pkg::WIDTH_W-1:0];
            pau_pkg::REG_IMAGE_HEIGHT:    height_in = csr.data[pau_pkg::HEIGHT_W-1:0];
            pau_pkg::REG_COLOR_THRESHOLD: thr_in    = csr.data[pau_pkg::THR_W-1:0];
            default:                      thr_in    = thr_ff;
         endcase
      end
   end

   // effective size: zero counts as one, larger than the maximum saturates
   always_comb begin
      if (width_ff == '0) begin
         eff_w = pau_pkg::WIDTH_W'(1);
      end else if (width_ff > pau_pkg::WIDTH_W'(pau_pkg::MAX_WIDTH)) begin
         eff_w = pau_pkg::WIDTH_W'(pau_pkg::MAX_WIDTH);
      end else begin
         eff_w = width_ff;
      end
      if (height_ff == '0) begin
         eff_h = pau_pkg::HEIGHT_W'(1);
      end else if (height_ff > pau_pkg::HEIGHT_W'(pau_pkg::MAX_HEIGHT)) begin
         eff_h = pau_pkg::HEIGHT_W'(pau_pkg::MAX_HEIGHT);
      end else begin
         eff_h = height_ff;
      end
   end

   assign x_next   = {1'b0, col_ff} + pau_pkg::WIDTH_W'(1);
   assign row_next = {1'b0, row_ff} + pau_pkg::HEIGHT_W'(1);
   assign addr1    = x_next[pau_pkg::COL_W-1:0];

   // classify the request and advance the raster counters
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      sel_in   = sel_ff;
      pend_in  = pend_ff;
      fetch_in = 1'b0;
      wr_en    = 1'b0;

      side_in.bottom    = req.pixel_color;
      side_in.col       = col_ff;
      side_in.row       = row_ff;
      side_in.use_top   = 1'b0;
      side_in.has_left  = (col_ff != '0);
      side_in.has_right = (x_next < eff_w);
      side_in.is_drain  = 1'b0;
      side_in.last      = 1'b0;

      if (accept) begin
         if (req.command == pau_pkg::CMD_DRAIN) begin
            // flush one block of the final row
            if (pend_ff != '0) begin
               fetch_in         = 1'b1;
               side_in.use_top  = (row_ff != '0);
               side_in.is_drain = 1'b1;
               side_in.last     = (pend_ff == pau_pkg::WIDTH_W'(1));
               pend_in          = pend_ff - pau_pkg::WIDTH_W'(1);
               if (pend_ff == pau_pkg::WIDTH_W'(1)) begin
                  col_in = '0;
                  row_in = '0;
               end else begin
                  col_in = x_next[pau_pkg::COL_W-1:0];
               end
            end
         end else if (pend_ff == '0) begin
            // source pixel; pixels while draining are dropped
            wr_en = 1'b1;
            if (row_ff != '0) begin
               fetch_in        = 1'b1;
               side_in.use_top = (row_ff > pau_pkg::ROW_W'(1));
               side_in.row     = row_ff - pau_pkg::ROW_W'(1);
            end
            if (x_next >= eff_w) begin
               col_in = '0;
               sel_in = ~sel_ff;
               if (row_next >= eff_h) begin
                  pend_in = eff_w;
               end else begin
                  row_in = row_next[pau_pkg::ROW_W-1:0];
               end
            end else begin
               col_in = x_next[pau_pkg::COL_W-1:0];
            end
         end
      end
   end

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= pau_pkg::WIDTH_W'(pau_pkg::WIDTH_RESET);
         height_ff <= pau_pkg::HEIGHT_W'(pau_pkg::HEIGHT_RESET);
         thr_ff    <= pau_pkg::THR_W'(pau_pkg::THR_RESET);
         thr_sq_ff <= pau_pkg::THR_SQ_W'(pau_pkg::THR_RESET * pau_pkg::THR_RESET);
         col_ff    <= '0;
         row_ff    <= '0;
         sel_ff    <= 1'b0;
         pend_ff   <= '0;
         fetch_ff  <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         thr_ff    <= thr_in;
         thr_sq_ff <= pau_pkg::THR_SQ_W'(thr_ff) * pau_pkg::THR_SQ_W'(thr_ff);
         col_ff    <= col_in;
         row_ff    <= row_in;
         sel_ff    <= sel_in;
         pend_ff   <= pend_in;
         fetch_ff  <= fetch_in;
      end
   end

   // line store reads (read before write) and side info of the fetch stage
   always_ff @(posedge clock) begin
      if (accept) begin
         cur0_ff <= sel_ff ? store_b_ff[col_ff] : store_a_ff[col_ff];
         cur1_ff <= sel_ff ? store_b_ff[addr1]  : store_a_ff[addr1];
         old_ff  <= sel_ff ? store_a_ff[col_ff] : store_b_ff[col_ff];
         side_ff <= side_in;
      end
   end

   // new pixel overwrites the older row in the other store
   always_ff @(posedge clock) begin
      if (wr_en && sel_ff) begin
         store_a_ff[col_ff] <= req.pixel_color;
      end
      if (wr_en && !sel_ff) begin
         store_b_ff[col_ff] <= req.pixel_color;
      end
   end

   assign push       = fetch_ff;
   assign job.center = cur0_ff;
   assign job.top    = old_ff;
   assign job.right  = cur1_ff;
   assign job.side   = side_ff;
   assign thr_sq     = thr_sq_ff;

endmodule

/* src/pau_back.sv */
// Back of the upscaler: neighbour selection, colour distance, blending.
// Two stages behind the queue; the second is the result register. Depends on pau_pkg.
module pau_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   input  pau_pkg::job_type                q_job,
   output logic                            pop,
   input  logic [pau_pkg::THR_SQ_W-1:0]    thr_sq,
   pau_rsp_if.source                       rsp
);

   typedef logic [2:0][pau_pkg::SQ_W-1:0] sq3_type;

   // per-channel squared differences of the RGB channels
   function automatic sq3_type chan_squares(pau_pkg::pixel_type a, pau_pkg::pixel_type b);
      sq3_type                     r;
      logic [pau_pkg::CHAN_W-1:0]  u;
      logic [pau_pkg::CHAN_W-1:0]  v;
      logic [pau_pkg::CHAN_W-1:0]  d;
      for (int c = 0; c < 3; c++) begin
         u    = a[c*pau_pkg::CHAN_W +: pau_pkg::CHAN_W];
         v    = b[c*pau_pkg::CHAN_W +: pau_pkg::CHAN_W];
         d    = (u > v) ? (u - v) : (v - u);
         r[c] = pau_pkg::SQ_W'(d) * pau_pkg::SQ_W'(d);
      end
      return r;
   endfunction

   function automatic logic [pau_pkg::DIST_W-1:0] sum3(sq3_type s);
      return pau_pkg::DIST_W'(s[0]) + pau_pkg::DIST_W'(s[1]) + pau_pkg::DIST_W'(s[2]);
   endfunction

   // truncating average per channel, alpha included
   function automatic pau_pkg::pixel_type blend(pau_pkg::pixel_type a, pau_pkg::pixel_type b);
      pau_pkg::pixel_type r;
      for (int c = 0; c < 4; c++) begin
         r[c*pau_pkg::CHAN_W +: pau_pkg::CHAN_W] = pau_pkg::CHAN_W'(
            ((pau_pkg::CHAN_W + 1)'(a[c*pau_pkg::CHAN_W +: pau_pkg::CHAN_W]) +
             (pau_pkg::CHAN_W + 1)'(b[c*pau_pkg::CHAN_W +: pau_pkg::CHAN_W])) >> 1);
      end
      return r;
   endfunction

   // handshake of the two stages
   logic                s1_ready, s2_ready;
   logic                s1_valid_ff, s1_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // neighbour to the left: centre of the last block taken from the queue
   pau_pkg::pixel_type  nb_left_ff;

   // stage 1
   pau_pkg::pixel_type  sel_top, sel_left, sel_right, sel_bottom;
   sq3_type             sq_lt_ff, sq_tr_ff, sq_lb_ff, sq_br_ff;
   pau_pkg::pixel_type  s1_center_ff, s1_top_ff, s1_left_ff, s1_right_ff;
   pau_pkg::col_type    s1_col_ff;
   pau_pkg::row_type    s1_row_ff;
   logic                s1_last_ff;

   // stage 2
   logic                diff_lt, diff_tr, diff_lb, diff_br;
   pau_pkg::pixel_type  tl_ff, tr_ff, bl_ff, br_ff;
   pau_pkg::col_type    col_ff;
   pau_pkg::row_type    row_ff;
   logic                last_ff;

   assign s2_ready = !rsp_valid_ff || rsp.ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign pop      = q_valid && s1_ready;

   always_comb begin
      s1_valid_in  = s1_ready ? q_valid : s1_valid_ff;
      rsp_valid_in = s2_ready ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // missing neighbours repeat the centre; the bottom of a drained row is the centre
   always_comb begin
      sel_top    = q_job.side.use_top   ? q_job.top    : q_job.center;
      sel_left   = q_job.side.has_left  ? nb_left_ff   : q_job.center;
      sel_right  = q_job.side.has_right ? q_job.right  : q_job.center;
      sel_bottom = q_job.side.is_drain  ? q_job.center : q_job.side.bottom;
   end

   // stage 1: squared channel differences of the four adjacent pairs
   always_ff @(posedge clock) begin
      if (pop) begin
         nb_left_ff   <= q_job.center;
         sq_lt_ff     <= chan_squares(sel_left, sel_top);
         sq_tr_ff     <= chan_squares(sel_top, sel_right);
         sq_lb_ff     <= chan_squares(sel_left, sel_bottom);
         sq_br_ff     <= chan_squares(sel_bottom, sel_right);
         s1_center_ff <= q_job.center;
         s1_top_ff    <= sel_top;
         s1_left_ff   <= sel_left;
         s1_right_ff  <= sel_right;
         s1_col_ff    <= q_job.side.col;
         s1_row_ff    <= q_job.side.row;
         s1_last_ff   <= q_job.side.last;
      end
   end

   // stage 2: threshold compare
   always_comb begin
      diff_lt = (pau_pkg::THR_SQ_W'(sum3(sq_lt_ff)) > thr_sq);
      diff_tr = (pau_pkg::THR_SQ_W'(sum3(sq_tr_ff)) > thr_sq);
      diff_lb = (pau_pkg::THR_SQ_W'(sum3(sq_lb_ff)) > thr_sq);
      diff_br = (pau_pkg::THR_SQ_W'(sum3(sq_br_ff)) > thr_sq);
   end

   // stage 2: quadrant blend into the result register
   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         tl_ff   <= diff_lt ? blend(s1_left_ff, s1_center_ff)  : s1_center_ff;
         tr_ff   <= diff_tr ? blend(s1_top_ff, s1_center_ff)   : s1_center_ff;
         bl_ff   <= diff_lb ? blend(s1_left_ff, s1_center_ff)  : s1_center_ff;
         br_ff   <= diff_br ? blend(s1_right_ff, s1_center_ff) : s1_center_ff;
         col_ff  <= s1_col_ff;
         row_ff  <= s1_row_ff;
         last_ff <= s1_last_ff;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.top_left      = tl_ff;
   assign rsp.top_right     = tr_ff;
   assign rsp.bottom_left   = bl_ff;
   assign rsp.bottom_right  = br_ff;
   assign rsp.block_column  = col_ff;
   assign rsp.block_row     = row_ff;
   assign rsp.last_of_frame = last_ff;

endmodule

/* src/pixel_art_2x_upscaler.sv */
// 2x pixel-art upscaler: one request a clock while the queue has room; a block passes
// the line-store read, queue, distance stage and result register after its request.
// Blocks of a row come out while the next row streams in; drain requests flush the last.
// Synchronous active-high reset clears counters, handshakes and configuration registers to defaults;
// line stores are not cleared and need no clearing pass.
`include "assert_macros.svh"

module pixel_art_2x_upscaler (
   input  logic        clock,
   input  logic        reset,
   pau_req_if.sink     req_port,
   pau_rsp_if.source   rsp_port,
   pau_csr_if.sink     csr_port
);

   logic                               push;
   pau_pkg::job_type                   job;
   logic                               q_valid;
   pau_pkg::job_type                   q_job;
   logic                               pop;
   pau_pkg::queue_status_type          q_status;
   logic [pau_pkg::THR_SQ_W-1:0]       thr_sq;

   // front: configuration, counters, line stores
   pau_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_port),
      .csr      (csr_port),
      .q_status (q_status),
      .push     (push),
      .job      (job),
      .thr_sq   (thr_sq)
   );

   // decoupling queue
   pau_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (job),
      .pop      (pop),
      .q_valid  (q_valid),
      .q_job    (q_job),
      .status   (q_status)
   );

   // back: distance test and blending
   pau_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_job    (q_job),
      .pop      (pop),
      .thr_sq   (thr_sq),
      .rsp      (rsp_port)
   );

   // no result straight after a reset cycle
   `PAU_ASSERT_RST(a_rsp_idle_after_reset, reset |=> !rsp_port.valid)
   // queue never fills beyond its depth
   `PAU_ASSERT(a_queue_bound, q_status.count <= pau_pkg::QCOUNT_W'(pau_pkg::QUEUE_DEPTH))
   // a block in the fetch stage always finds a free slot
   `PAU_ASSERT(a_fetch_room, push |-> (q_status.count < pau_pkg::QCOUNT_W'(pau_pkg::QUEUE_DEPTH)))

endmodule

/* dv/pixel_art_2x_upscaler_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for pixel_art_2x_upscaler: pixel and drain requests go in,
// and every 2x2 block that comes out is checked against a built-in line-store predictor.
// Depends on pau_pkg and the pau_req_if, pau_rsp_if and pau_csr_if interfaces.
module pixel_art_2x_upscaler_test;

   localparam int RANDOM_ITEMS   = 260;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 8;

   typedef struct packed {
      pau_pkg::pixel_type top_left;
      pau_pkg::pixel_type top_right;
      pau_pkg::pixel_type bottom_left;
      pau_pkg::pixel_type bottom_right;
      pau_pkg::col_type   column;
      pau_pkg::row_type   row;
      logic               last;
   } upscaled_block_type;

   logic clock;
   logic reset;

   pau_req_if req_bus ();
   pau_rsp_if rsp_bus ();
   pau_csr_if csr_bus ();

   pixel_art_2x_upscaler uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   // Predictor state: register copies, two line stores, position and flush count
   logic [pau_pkg::WIDTH_W-1:0]  cfg_width;
   logic [pau_pkg::HEIGHT_W-1:0] cfg_height;
   logic [pau_pkg::THR_W-1:0]    cfg_threshold;
   pau_pkg::pixel_type           line_store [2][pau_pkg::MAX_WIDTH];
   pau_pkg::pixel_type           left_pix;
   int                           col_pos;
   int                           row_pos;
   bit                           store_sel;
   int                           blocks_to_flush;

   upscaled_block_type           pending_blocks [$];
   pau_pkg::pixel_type           colour_set [4];

   bit req_steady;
   bit rsp_steady;
   int rsp_hold;
   int quiet_cycles = 0;
   int mismatch_count;
   int blocks_checked;
   int requests_sent;
   int useful_items;
   int frames_done;
   int settings_loaded;

   // Clock
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Effective geometry: zero counts as one, oversize saturates
   function automatic int active_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > pau_pkg::MAX_WIDTH) return pau_pkg::MAX_WIDTH;
      return int'(cfg_width);
   endfunction

   function automatic int active_height();
      if (cfg_height == 0) return 1;
      if (cfg_height > pau_pkg::MAX_HEIGHT) return pau_pkg::MAX_HEIGHT;
      return int'(cfg_height);
   endfunction

   // Squared RGB distance against threshold squared, alpha left out
   function automatic bit colours_differ(input pau_pkg::pixel_type a,
                                         input pau_pkg::pixel_type b);
      int sum;
      int d;
      sum = 0;
      for (int ch = 0; ch < 3; ch++) begin
         d = int'(a[8*ch +: 8]) - int'(b[8*ch +: 8]);
         sum += d * d;
      end
      return sum > int'(cfg_threshold) * int'(cfg_threshold);
   endfunction

   // Per-channel truncating average, alpha included
   function automatic pau_pkg::pixel_type blend_pixels(input pau_pkg::pixel_type a,
                                                       input pau_pkg::pixel_type b);
      pau_pkg::pixel_type r;
      for (int ch = 0; ch < 4; ch++)
         r[8*ch +: 8] = 8'((9'(a[8*ch +: 8]) + 9'(b[8*ch +: 8])) >> 1);
      return r;
   endfunction

   function automatic upscaled_block_type make_block(input pau_pkg::pixel_type centre, above,
                                                     left_px, right_px, below,
                                                     input int col, row,
                                                     input bit last_one);
      upscaled_block_type b;
      b.top_left     = colours_differ(left_px, above) ? blend_pixels(left_px, centre) : centre;
      b.top_right    = colours_differ(above, right_px) ? blend_pixels(above, centre) : centre;
      b.bottom_left  = colours_differ(left_px, below) ? blend_pixels(left_px, centre) : centre;
      b.bottom_right = colours_differ(below, right_px) ? blend_pixels(right_px, centre) : centre;
      b.column       = pau_pkg::col_type'(col);
      b.row          = pau_pkg::row_type'(row);
      b.last         = last_one;
      return b;
   endfunction

   // Advance the predictor by one accepted request; returns 1 when a block is due
   function automatic bit upscale_step(input logic cmd, input pau_pkg::pixel_type colour,
                                       output upscaled_block_type blk);
      int                 w;
      int                 h;
      int                 x;
      bit                 produced;
      pau_pkg::pixel_type centre;
      pau_pkg::pixel_type above;
      pau_pkg::pixel_type left_px;
      pau_pkg::pixel_type right_px;
      w = active_width();
      h = active_height();
      x = col_pos;
      blk = '0;
      produced = 1'b0;

      // Drain: flush one block of the final row
      if (cmd == pau_pkg::CMD_DRAIN) begin
         if (blocks_to_flush == 0) return 1'b0;
         centre   = line_store[store_sel][x];
         above    = (row_pos > 0) ? line_store[store_sel ^ 1'b1][x] : centre;
         left_px  = (x > 0) ? left_pix : centre;
         right_px = (x + 1 < w) ? line_store[store_sel][x + 1] : centre;
         blk = make_block(centre, above, left_px, right_px, centre, x, row_pos,
                          blocks_to_flush == 1);
         left_pix = centre;
         blocks_to_flush--;
         if (blocks_to_flush == 0) begin
            col_pos  = 0;
            row_pos  = 0;
            left_pix = '0;
         end else begin
            col_pos = x + 1;
         end
         return 1'b1;
      end

      // Pixels are ignored while the last row is being flushed
      if (blocks_to_flush != 0) return 1'b0;

      // Pixel: emit the block above it (not on the first row), then store it
      if (row_pos > 0) begin
         centre   = line_store[store_sel][x];
         above    = (row_pos > 1) ? line_store[store_sel ^ 1'b1][x] : centre;
         left_px  = (x > 0) ? left_pix : centre;
         right_px = (x + 1 < w) ? line_store[store_sel][x + 1] : centre;
         blk = make_block(centre, above, left_px, right_px, colour, x, row_pos - 1, 1'b0);
         left_pix = centre;
         produced = 1'b1;
      end
      line_store[store_sel ^ 1'b1][x] = colour;
      if (x + 1 >= w) begin
         col_pos   = 0;
         left_pix  = '0;
         store_sel ^= 1'b1;
         if (row_pos + 1 >= h) blocks_to_flush = w;
         else row_pos++;
      end else begin
         col_pos = x + 1;
      end
      return produced;
   endfunction

   // Sender gap: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      if (req_steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Image content: a small palette, near copies of it and the odd random pixel
   function automatic pau_pkg::pixel_type pick_colour();
      int                 r;
      pau_pkg::pixel_type base;
      r = $urandom_range(0, 99);
      base = colour_set[$urandom_range(0, 3)];
      if (r < 60) return base;
      if (r < 85)
         return base ^ (pau_pkg::pixel_type'($urandom_range(1, 31)) << (8 * $urandom_range(0, 3)));
      return $urandom();
   endfunction

   function automatic void refresh_palette();
      colour_set[0] = $urandom();
      for (int i = 1; i < 4; i++)
         colour_set[i] = ($urandom_range(0, 1) == 0) ? pau_pkg::pixel_type'($urandom())
                         : colour_set[0] ^ (pau_pkg::pixel_type'($urandom_range(0, 63)) << (8 * i));
   endfunction

   // Random junk above the register width, now and then
   function automatic logic [pau_pkg::CSR_DATA_W-1:0] with_spare_bits(input int value,
                                                                      input int bits);
      logic [pau_pkg::CSR_DATA_W-1:0] v;
      v = pau_pkg::CSR_DATA_W'(value);
      if ($urandom_range(0, 9) == 0)
         v |= pau_pkg::CSR_DATA_W'($urandom()) & ({pau_pkg::CSR_DATA_W{1'b1}} << bits);
      return v;
   endfunction

   // Send one request and update the predictor at its acceptance
   task automatic send_request(input logic cmd, input pau_pkg::pixel_type colour);
      int                 gap;
      upscaled_block_type blk;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.command     <= cmd;
      req_bus.pixel_color <= colour;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      requests_sent++;
      if (upscale_step(cmd, colour, blk)) pending_blocks.push_back(blk);
   endtask

   // Hold off until every block due has come out and the pipeline has settled
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_blocks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input pau_pkg::csr_index_type idx,
                                 input logic [pau_pkg::CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         pau_pkg::REG_IMAGE_WIDTH:     cfg_width     = value[pau_pkg::WIDTH_W-1:0];
         pau_pkg::REG_IMAGE_HEIGHT:    cfg_height    = value[pau_pkg::HEIGHT_W-1:0];
         pau_pkg::REG_COLOR_THRESHOLD: cfg_threshold = value[pau_pkg::THR_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_settings(input logic [pau_pkg::CSR_DATA_W-1:0] width_val, height_val,
                                thr_val);
      write_register(pau_pkg::REG_IMAGE_WIDTH, width_val);
      write_register(pau_pkg::REG_IMAGE_HEIGHT, height_val);
      write_register(pau_pkg::REG_COLOR_THRESHOLD, thr_val);
      csr_bus.valid <= 1'b0;
      settings_loaded++;
   endtask

   // One whole frame at the current geometry, then its flush; optional stray requests
   task automatic send_image(input int noise_pct);
      int cols;
      int rows;
      cols = active_width();
      rows = active_height();
      for (int y = 0; y < rows; y++) begin
         for (int x = 0; x < cols; x++) begin
            if ($urandom_range(0, 99) < noise_pct) send_request(pau_pkg::CMD_DRAIN, $urandom());
            if ($urandom_range(0, 199) == 0) wait_idle();
            send_request(pau_pkg::CMD_PIXEL, pick_colour());
         end
      end
      for (int x = 0; x < cols; x++) begin
         if ($urandom_range(0, 99) < noise_pct) send_request(pau_pkg::CMD_PIXEL, $urandom());
         send_request(pau_pkg::CMD_DRAIN, $urandom());
      end
      useful_items += cols * rows + cols;
      frames_done++;
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] want, got,
                                  input upscaled_block_type blk);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("block col %0d row %0d: %s expected %h, got %h",
                  blk.column, blk.row, field, want, got);
   endtask

   // Compare one accepted block with the oldest one predicted
   task automatic check_block();
      upscaled_block_type want;
      blocks_checked++;
      if (pending_blocks.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected block at col %0d row %0d",
                     rsp_bus.block_column, rsp_bus.block_row);
         return;
      end
      want = pending_blocks.pop_front();
      if (rsp_bus.top_left !== want.top_left)
         report_mismatch("top_left", want.top_left, rsp_bus.top_left, want);
      if (rsp_bus.top_right !== want.top_right)
         report_mismatch("top_right", want.top_right, rsp_bus.top_right, want);
      if (rsp_bus.bottom_left !== want.bottom_left)
         report_mismatch("bottom_left", want.bottom_left, rsp_bus.bottom_left, want);
      if (rsp_bus.bottom_right !== want.bottom_right)
         report_mismatch("bottom_right", want.bottom_right, rsp_bus.bottom_right, want);
      if (rsp_bus.block_column !== want.column)
         report_mismatch("block_column", 32'(want.column), 32'(rsp_bus.block_column), want);
      if (rsp_bus.block_row !== want.row)
         report_mismatch("block_row", 32'(want.row), 32'(rsp_bus.block_row), want);
      if (rsp_bus.last_of_frame !== want.last)
         report_mismatch("last_of_frame", 32'(want.last), 32'(rsp_bus.last_of_frame), want);
   endtask

   // Result side: check each block, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) check_block();
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_steady || $urandom_range(0, 99) < 70) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b0;
            rsp_hold = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 30)
                       : $urandom_range(0, 2);
         end
      end
   end

   // Watchdog: nothing moving on any channel for too long
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no handshake for %0d cycles, %0d blocks outstanding",
                  quiet_cycles, pending_blocks.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Reset geometry: one full row at the reset width and three pixels more, then shrink below the current column
   task automatic test_defaults_and_shrink();
      refresh_palette();
      repeat (pau_pkg::WIDTH_RESET + 3) send_request(pau_pkg::CMD_PIXEL, pick_colour());
      wait_idle();
      load_settings(2, 2, 48);
      send_request(pau_pkg::CMD_PIXEL, pick_colour());
      repeat (2) send_request(pau_pkg::CMD_DRAIN, $urandom());
      useful_items += pau_pkg::WIDTH_RESET + 6;
      frames_done++;
   endtask

   // Field extremes, alpha-only differences, stray drains and pixels while flushing
   task automatic test_directed_corners();
      pau_pkg::pixel_type pic [9];
      pic = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h80FF_00FF,
              32'hFF00_0000, 32'h00FF_FFFE, 32'h7F00_FF00,
              32'h1234_5678, 32'h1234_5679, 32'hEDCB_A987};
      wait_idle();
      load_settings(3, 3, 48);
      send_request(pau_pkg::CMD_DRAIN, 32'hFFFF_FFFF);
      foreach (pic[i]) send_request(pau_pkg::CMD_PIXEL, pic[i]);
      send_request(pau_pkg::CMD_DRAIN, 32'h0000_0000);
      send_request(pau_pkg::CMD_PIXEL, 32'hFFFF_FFFF);
      repeat (2) send_request(pau_pkg::CMD_DRAIN, $urandom());
      send_request(pau_pkg::CMD_DRAIN, $urandom());
      useful_items += 12;
      frames_done++;
   endtask

   // Distance exactly at the threshold is equal, one more is different; then 0 and 511
   task automatic test_threshold_limits();
      wait_idle();
      load_settings(2, 2, 5);
      send_request(pau_pkg::CMD_PIXEL, 32'h0000_0000);
      send_request(pau_pkg::CMD_PIXEL, 32'h0003_0400);
      send_request(pau_pkg::CMD_PIXEL, 32'h0003_0401);
      send_request(pau_pkg::CMD_PIXEL, 32'hFF00_0000);
      repeat (2) send_request(pau_pkg::CMD_DRAIN, $urandom());
      useful_items += 6;
      frames_done++;
      wait_idle();
      load_settings(3, 2, 0);
      refresh_palette();
      send_image(0);
      wait_idle();
      load_settings(3, 2, 511);
      send_image(0);
   endtask

   // Zero sizes count as one; oversize sizes keep the row or frame open, then shrink
   task automatic test_size_extremes();
      wait_idle();
      load_settings(16'h0000, 16'h0000, 16'hFE30);
      send_image(0);

      // Oversize width: three pixels leave the first row open
      wait_idle();
      load_settings(16'hFFFF, 16'h0002, 16'h0030);
      refresh_palette();
      repeat (3) send_request(pau_pkg::CMD_PIXEL, pick_colour());
      wait_idle();
      load_settings(16'h0002, 16'h0002, 16'h0030);
      repeat (3) send_request(pau_pkg::CMD_PIXEL, pick_colour());
      repeat (2) send_request(pau_pkg::CMD_DRAIN, $urandom());
      useful_items += 8;
      frames_done++;

      // Oversize height: three one-pixel rows leave the frame open
      wait_idle();
      load_settings(16'h0001, 16'hFFFF, 16'h0030);
      repeat (3) send_request(pau_pkg::CMD_PIXEL, pick_colour());
      wait_idle();
      load_settings(16'h0001, 16'h0001, 16'h0030);
      send_request(pau_pkg::CMD_PIXEL, pick_colour());
      send_request(pau_pkg::CMD_DRAIN, $urandom());
      useful_items += 5;
      frames_done++;
   endtask

   // Random small frames under random settings, with stray requests and pauses
   task automatic test_random_frames();
      int start;
      int w;
      int h;
      int thr;
      int r;
      start = useful_items;
      while (useful_items - start < RANDOM_ITEMS) begin
         if (useful_items == start || $urandom_range(0, 2) == 0) begin
            w = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 10) : $urandom_range(11, 24);
            h = $urandom_range(1, 6);
            r = $urandom_range(0, 99);
            thr = (r < 10) ? 0 : (r < 20) ? $urandom_range(400, 511) : $urandom_range(0, 96);
            wait_idle();
            load_settings(with_spare_bits(w, pau_pkg::WIDTH_W),
                          with_spare_bits(h, pau_pkg::HEIGHT_W),
                          with_spare_bits(thr, pau_pkg::THR_W));
         end
         req_steady = ($urandom_range(0, 4) == 0);
         rsp_steady = ($urandom_range(0, 4) == 0);
         refresh_palette();
         send_image(4);
      end
      req_steady = 1'b0;
      rsp_steady = 1'b0;
   endtask

   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.command     = pau_pkg::CMD_PIXEL;
      req_bus.pixel_color = '0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = pau_pkg::REG_IMAGE_WIDTH;
      csr_bus.data        = '0;
      cfg_width           = pau_pkg::WIDTH_W'(pau_pkg::WIDTH_RESET);
      cfg_height          = pau_pkg::HEIGHT_W'(pau_pkg::HEIGHT_RESET);
      cfg_threshold       = pau_pkg::THR_W'(pau_pkg::THR_RESET);
      left_pix            = '0;
      col_pos             = 0;
      row_pos             = 0;
      store_sel           = 1'b0;
      blocks_to_flush     = 0;
      req_steady          = 1'b0;
      rsp_steady          = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_defaults_and_shrink();
      test_directed_corners();
      test_threshold_limits();
      test_size_extremes();
      test_random_frames();

      // Drain out and give late or extra blocks a chance to show up
      wait_idle();
      repeat (12) @(posedge clock);

      $display("%0d requests sent, %0d blocks checked, %0d mismatches",
               requests_sent, blocks_checked, mismatch_count);
      $display("%0d frames over %0d register settings, incl. zero, oversize and shrunk sizes",
               frames_done, settings_loaded);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+src
src/pau_pkg.sv
src/pau_req_if.sv
src/pau_rsp_if.sv
src/pau_csr_if.sv
src/pau_queue.sv
src/pau_front.sv
src/pau_back.sv
src/pixel_art_2x_upscaler.sv
dv/pixel_art_2x_upscaler_test.sv
